// File: sv/lpcp_pkg.sv
// Shared types and constants for the lidar point to camera projection block.
// Depends on nothing; every other file imports it.
`default_nettype none
package lpcp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROT0  = 3'd0;
  localparam logic [2:0] REG_ROT1  = 3'd1;
  localparam logic [2:0] REG_ROT2  = 3'd2;
  localparam logic [2:0] REG_TRANS = 3'd3;
  localparam logic [2:0] REG_FOCAL = 3'd4;
  localparam logic [2:0] REG_PRINC = 3'd5;
  localparam logic [2:0] REG_IMAGE = 3'd6;
  localparam logic [2:0] REG_MIND  = 3'd7;

  localparam int CoefW  = 18;   // signed Q1.16 coefficient
  localparam int PointW = 24;   // signed Q13.10 coordinate
  localparam int CamW   = 28;   // camera frame coordinate, Q.10
  localparam int ProdW  = 61;   // Q21.10 times camera coordinate
  localparam int NumW   = 62;   // projection numerator
  localparam int DenW   = 37;   // depth times 1024
  localparam int RemW   = 49;   // remainder once the numerator is below 4096 * den
  localparam int QuoW   = 12;   // pixel index bits

  localparam logic [23:0] ImageReset = 24'd2950400;
  localparam logic [15:0] MinDepthReset = 16'd205;
  localparam logic [7:0]  ColourMax = 8'd250;
  localparam logic signed [CamW-1:0] DepthFull = 28'sd8192;

  // Side information that travels alongside the two dividers.
  typedef struct packed {
    logic       ok;
    logic [7:0] depth;
  } side_t;

  function automatic logic signed [CoefW-1:0] coef(input logic [53:0] packed_row,
                                                   input int k);
    coef = $signed(packed_row[k*CoefW +: CoefW]);
  endfunction

endpackage
`default_nettype wire

// File: sv/lidar_point_camera_projection.sv
// Top level of the lidar point to camera pixel projection pipeline.
// Depends on lpcp_pkg and lpcp_divider.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  x, y, z signed Q13.10
//  m_axis    out        m_axis_tvalid/m_axis_tready  column, row, red, blue; tuser visible
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One word enters per cycle unless the output word is held. Four stages do the
// rigid transform, the projection products and the range checks, twelve
// stages run the two restoring dividers one quotient bit each, and a last stage
// registers the result. Reset clears the valid bits and loads the register
// reset values. When the output word is held, the whole pipeline freezes, so
// nothing is lost or repeated; bubbles in flight stay where they are while it is frozen.
`default_nettype none
module lidar_point_camera_projection
  import lpcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // point_x[23:0], point_y[47:24], point_z[71:48]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // column[11:0], row_index[23:12],
                                           // red_level[31:24], blue_level[39:32]
  output logic             m_axis_tuser,   // visible
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int Stages = 17;

  // Configuration registers.
  logic [53:0] rot [3];
  logic [53:0] trans;
  logic [63:0] focal;
  logic [63:0] princ;
  logic [23:0] image;
  logic [15:0] min_depth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]    <= '0;
      rot[1]    <= '0;
      rot[2]    <= '0;
      trans     <= '0;
      focal     <= '0;
      princ     <= '0;
      image     <= ImageReset;
      min_depth <= MinDepthReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROT0:  rot[0]    <= cfg_data[53:0];
        REG_ROT1:  rot[1]    <= cfg_data[53:0];
        REG_ROT2:  rot[2]    <= cfg_data[53:0];
        REG_TRANS: trans     <= cfg_data[53:0];
        REG_FOCAL: focal     <= cfg_data;
        REG_PRINC: princ     <= cfg_data;
        REG_IMAGE: image     <= cfg_data[23:0];
        REG_MIND:  min_depth <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // The pipeline advances unless the output holds a word that is not taken.
  logic              en;
  logic [Stages:1]   vld;

  assign en            = !vld[Stages] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-1:1], s_axis_tvalid};
    end
  end

  // Stage 1: the nine rotation products and the translation.
  logic signed [PointW-1:0] pin [3];
  logic signed [41:0]       s1_prod [3][3];
  logic signed [CoefW-1:0]  s1_trans [3];

  assign pin[0] = $signed(s_axis_tdata[23:0]);
  assign pin[1] = $signed(s_axis_tdata[47:24]);
  assign pin[2] = $signed(s_axis_tdata[71:48]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod[r][c] <= coef(rot[r], c) * pin[c];
        end
        s1_trans[r] <= coef(trans, r);
      end
    end
  end

  // Stage 2: row sums plus translation, floored from Q.26 to Q.10.
  logic signed [43:0]     acc [3];
  logic signed [CamW-1:0] s2_cam [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 44'(s1_prod[r][0]) + 44'(s1_prod[r][1]) + 44'(s1_prod[r][2])
             + (44'(s1_trans[r]) <<< 10);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s2_cam[r] <= acc[r][43:16];
      end
    end
  end

  // Stage 3: projection products, divisor, depth test and depth colour.
  logic signed [ProdW-1:0] s3_ua, s3_ub, s3_va, s3_vb;
  logic [DenW-1:0]         s3_den;
  logic                    s3_front;
  logic [7:0]              s3_depth;
  logic [7:0]              depth_lvl;
  logic [20:0]             depth_scaled;

  assign depth_scaled = 21'(s2_cam[2][12:0]) * 21'(ColourMax);

  always_comb begin
    priority if (s2_cam[2] <= 0) begin
      depth_lvl = '0;
    end else if (s2_cam[2] >= DepthFull) begin
      depth_lvl = ColourMax;
    end else begin
      depth_lvl = depth_scaled[20:13];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ua    <= $signed({1'b0, focal[31:0]}) * s2_cam[0];
      s3_ub    <= $signed({1'b0, princ[31:0]}) * s2_cam[2];
      s3_va    <= $signed({1'b0, focal[63:32]}) * s2_cam[1];
      s3_vb    <= $signed({1'b0, princ[63:32]}) * s2_cam[2];
      s3_den   <= {s2_cam[2][26:0], 10'b0};
      s3_front <= s2_cam[2] > $signed({12'b0, min_depth});
      s3_depth <= depth_lvl;
    end
  end

  // Stage 4: numerators, sign and range checks that bound the quotient.
  logic signed [NumW-1:0] nu, nv;
  logic [NumW-2:0]        lim;
  logic [RemW-1:0]        s4_nu, s4_nv;
  logic [DenW-1:0]        s4_den;
  side_t                  s4_side;

  assign nu  = NumW'(s3_ua) + NumW'(s3_ub);
  assign nv  = NumW'(s3_va) + NumW'(s3_vb);
  assign lim = {12'b0, s3_den, 12'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nu         <= nu[RemW-1:0];
      s4_nv         <= nv[RemW-1:0];
      s4_den        <= s3_den;
      s4_side.ok    <= s3_front && !nu[NumW-1] && !nv[NumW-1]
                       && (nu[NumW-2:0] < lim) && (nv[NumW-2:0] < lim);
      s4_side.depth <= s3_depth;
    end
  end

  // Stages 5 to 16: the two dividers, with side information in step.
  logic [QuoW-1:0] quo_u, quo_v;
  side_t           side_d [1:QuoW];

  lpcp_divider u_div_u (.clk(clk), .en(en), .num(s4_nu), .den(s4_den), .quo(quo_u));
  lpcp_divider u_div_v (.clk(clk), .en(en), .num(s4_nv), .den(s4_den), .quo(quo_v));

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[1] <= s4_side;
      for (int k = 2; k <= QuoW; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // Stage 17: image bounds and the output word.
  logic vis;
  assign vis = side_d[QuoW].ok && (quo_u < image[11:0]) && (quo_v < image[23:12]);

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser        <= vis;
      m_axis_tdata[11:0]  <= vis ? quo_u : '0;
      m_axis_tdata[23:12] <= vis ? quo_v : '0;
      m_axis_tdata[31:24] <= side_d[QuoW].depth;
      m_axis_tdata[39:32] <= ColourMax - side_d[QuoW].depth;
    end
  end

endmodule
`default_nettype wire

// File: sv/lpcp_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on lpcp_pkg for the operand widths.
`default_nettype none
module lpcp_divider
  import lpcp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [RemW-1:0]  num,
  input  wire logic [DenW-1:0]  den,
  output logic      [QuoW-1:0]  quo
);

  logic [RemW-1:0] rem  [QuoW+1];
  logic [DenW-1:0] dsr  [QuoW+1];
  logic [QuoW-1:0] qacc [QuoW+1];

  assign rem[0]  = num;
  assign dsr[0]  = den;
  assign qacc[0] = '0;

  for (genvar j = 0; j < QuoW; j++) begin : g_step
    localparam int Sh = QuoW - 1 - j;
    logic [RemW-1:0] trial;
    logic            ge;
    assign trial = {{(RemW-DenW){1'b0}}, dsr[j]} << Sh;
    assign ge    = rem[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? rem[j] - trial : rem[j];
        dsr[j+1]  <= dsr[j];
        qacc[j+1] <= {qacc[j][QuoW-2:0], ge};
      end
    end
  end

  assign quo = qacc[QuoW];

endmodule
`default_nettype wire

// File: sv/lpcp_checker.sv
// Port level checks for the projection block, bound to its top level.
// Depends on lpcp_pkg and the top level's port names.
`default_nettype none
module lpcp_checker
  import lpcp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A held output word keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while held");

  // A point off the image reports pixel zero.
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
    else $error("hidden point carries a pixel");

  // Red and blue always share the full colour range.
  a_colour_sum: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 9'(m_axis_tdata[31:24]) + 9'(m_axis_tdata[39:32]) == 9'(ColourMax))
    else $error("colour components do not add up");

  // Input is only held back by a waiting output word.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // Nothing leaves right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind lidar_point_camera_projection lpcp_checker u_lpcp_checker (.*);
`default_nettype wire
